@@ sv/prrs_pkg.sv @@
// Shared constants, types and cell command codes for the task scheduler.
// No dependencies; every other file of the scheduler refers to this package.
package prrs_pkg;

    localparam int MAX_TASKS  = 8;
    localparam int NUM_PRIOS  = 32;
    localparam int DELAY_BITS = 16;

    localparam int ID_W    = $clog2(MAX_TASKS);
    localparam int PRIO_W  = $clog2(NUM_PRIOS);
    localparam int RANK_W  = ID_W;
    localparam int CMD_W   = 3;
    localparam int SLICE_W = 8;
    localparam int LOCK_W  = 8;

    localparam logic [LOCK_W-1:0]  LOCK_MAX    = 8'd255;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

    // Request command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELAY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd4;

    // Operations broadcast to the row of slot cells
    typedef enum logic [3:0] {
        OP_NOP,
        OP_REMOVE,
        OP_CREATE,
        OP_DELAY,
        OP_WAKE,
        OP_DEC,
        OP_SLICE_DEC,
        OP_SLICE_RELOAD,
        OP_SLICE_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [ID_W-1:0]        tgt;
        logic [PRIO_W-1:0]      prio;
        logic [RANK_W-1:0]      rank;
        logic [RANK_W-1:0]      tail;
        logic [DELAY_BITS-1:0]  delay;
        logic [SLICE_W-1:0]     full;
    } cell_cmd_t;

    typedef struct packed {
        logic                   used;
        logic                   ready;
        logic                   delayed;
        logic [PRIO_W-1:0]      prio;
        logic [RANK_W-1:0]      rank;
        logic [DELAY_BITS-1:0]  dl;
        logic [SLICE_W-1:0]     slice;
    } cell_stat_t;

    typedef struct packed {
        logic                   found;
        logic [PRIO_W-1:0]      prio;
        logic [RANK_W-1:0]      rank;
        logic [ID_W-1:0]        idx;
    } pick_t;

endpackage

@@ sv/prrs_req_if.sv @@
// Request channel interface: command and its operands with valid/ready.
// Depends on prrs_pkg for field widths.
interface prrs_req_if;
    logic                             valid;
    logic                             ready;
    logic [prrs_pkg::CMD_W-1:0]       cmd;
    logic [prrs_pkg::ID_W-1:0]        task_id;
    logic [prrs_pkg::PRIO_W-1:0]      task_prio;
    logic [prrs_pkg::DELAY_BITS-1:0]  delay_ticks;

    modport source (output valid, cmd, task_id, task_prio, delay_ticks, input ready);
    modport sink   (input valid, cmd, task_id, task_prio, delay_ticks, output ready);
endinterface

@@ sv/prrs_rsp_if.sv @@
// Response channel interface: scheduling decision with valid/ready.
// Depends on prrs_pkg for field widths.
interface prrs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [prrs_pkg::ID_W-1:0]    run_task;
    logic                         switch_now;
    logic                         none_ready;
    logic [prrs_pkg::LOCK_W-1:0]  lock_depth;

    modport source (output valid, run_task, switch_now, none_ready, lock_depth, input ready);
    modport sink   (input valid, run_task, switch_now, none_ready, lock_depth, output ready);
endinterface

@@ sv/prrs_cfg_if.sv @@
// Configuration write channel interface carrying the slice length.
// Depends on prrs_pkg for the data width.
interface prrs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [prrs_pkg::SLICE_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ sv/prrs_cell.sv @@
// One task slot cell: holds the slot state, applies the broadcast operation
// and passes the best-so-far pick to its neighbor. Depends on prrs_pkg.
module prrs_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [prrs_pkg::ID_W-1:0]  idx,
    input  prrs_pkg::cell_cmd_t        bc,
    input  prrs_pkg::pick_t            pick_in,
    output prrs_pkg::cell_stat_t       stat,
    output prrs_pkg::pick_t            pick_out
);

    prrs_pkg::cell_stat_t st_reg;
    logic is_tgt;
    logic peer;
    logic peer_after;

    assign stat       = st_reg;
    assign is_tgt     = (idx == bc.tgt);
    assign peer       = !is_tgt && st_reg.ready && (st_reg.prio == bc.prio);
    assign peer_after = peer && (st_reg.rank > bc.rank);

    // Apply the broadcast operation to this slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            case (bc.op)
                prrs_pkg::OP_REMOVE, prrs_pkg::OP_DELAY:
                begin
                    if (peer_after)
                        st_reg.rank <= st_reg.rank - 1'b1;
                    if (is_tgt)
                    begin
                        st_reg.ready <= 1'b0;
                        st_reg.rank  <= '0;
                        if (bc.op == prrs_pkg::OP_DELAY)
                        begin
                            st_reg.delayed <= 1'b1;
                            st_reg.dl      <= bc.delay;
                        end
                    end
                end
                prrs_pkg::OP_CREATE, prrs_pkg::OP_WAKE:
                begin
                    if (peer)
                        st_reg.rank <= st_reg.rank + 1'b1;
                    if (is_tgt)
                    begin
                        st_reg.ready   <= 1'b1;
                        st_reg.rank    <= '0;
                        st_reg.delayed <= 1'b0;
                        st_reg.dl      <= '0;
                        if (bc.op == prrs_pkg::OP_CREATE)
                        begin
                            st_reg.used  <= 1'b1;
                            st_reg.prio  <= bc.prio;
                            st_reg.slice <= bc.full;
                        end
                    end
                end
                prrs_pkg::OP_DEC:
                begin
                    if (is_tgt)
                        st_reg.dl <= st_reg.dl - 1'b1;
                end
                prrs_pkg::OP_SLICE_DEC:
                begin
                    if (is_tgt)
                        st_reg.slice <= st_reg.slice - 1'b1;
                end
                prrs_pkg::OP_SLICE_RELOAD:
                begin
                    if (is_tgt)
                        st_reg.slice <= bc.full;
                end
                prrs_pkg::OP_SLICE_ROT:
                begin
                    if (peer_after)
                        st_reg.rank <= st_reg.rank - 1'b1;
                    if (is_tgt)
                    begin
                        st_reg.rank  <= bc.tail;
                        st_reg.slice <= bc.full;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Take over the pick when this slot beats the best so far
    always_comb
    begin
        pick_out = pick_in;
        if (st_reg.ready && (!pick_in.found || st_reg.prio < pick_in.prio ||
            (st_reg.prio == pick_in.prio && st_reg.rank < pick_in.rank)))
        begin
            pick_out.found = 1'b1;
            pick_out.prio  = st_reg.prio;
            pick_out.rank  = st_reg.rank;
            pick_out.idx   = idx;
        end
    end

endmodule

@@ sv/priority_round_robin_task_scheduler.sv @@
// Priority scheduler with round-robin slices: a sequencer drives a row of slot cells.
// Create, delay, tick run states CREATE_RM/ADD, DELAY, TICK_SCAN/SLICE before PICK.
// One request is in flight at a time; the tick scan visits one slot cell per cycle.
// The next request is taken while a response still waits in the output register.
// Reset (rst_n low, asynchronous): all slots empty, no current task, lock 0, slice 10.
// Depends on prrs_pkg, prrs_req_if, prrs_rsp_if, prrs_cfg_if and prrs_cell.
module priority_round_robin_task_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    prrs_req_if.sink    req,
    prrs_rsp_if.source  rsp,
    prrs_cfg_if.sink    cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE_RM,
        S_CREATE_ADD,
        S_DELAY,
        S_TICK_SCAN,
        S_TICK_SLICE,
        S_PICK
    } state_t;

    state_t                              state_reg;
    logic [prrs_pkg::ID_W-1:0]           tid_reg;
    logic [prrs_pkg::PRIO_W-1:0]         prio_reg;
    logic [prrs_pkg::DELAY_BITS-1:0]     dly_reg;
    logic [prrs_pkg::ID_W-1:0]           scan_reg;
    logic [prrs_pkg::ID_W-1:0]           cur_reg;
    logic                                cur_valid_reg;
    logic [prrs_pkg::LOCK_W-1:0]         lock_reg;
    logic [prrs_pkg::SLICE_W-1:0]        slice_len_reg;
    logic                                out_valid_reg;
    logic [prrs_pkg::ID_W-1:0]           out_run_reg;
    logic                                out_switch_reg;
    logic                                out_none_reg;
    logic [prrs_pkg::LOCK_W-1:0]         out_lock_reg;

    prrs_pkg::cell_cmd_t                 bc;
    prrs_pkg::cell_stat_t                stat [prrs_pkg::MAX_TASKS];
    prrs_pkg::pick_t                     chain [prrs_pkg::MAX_TASKS+1];
    logic [prrs_pkg::MAX_TASKS-1:0]      ready_vec;
    logic [prrs_pkg::RANK_W:0]           peer_cnt;
    logic [prrs_pkg::SLICE_W-1:0]        full_slice;
    logic                                accept;
    logic                                out_free;
    logic                                pick_valid;
    logic [prrs_pkg::ID_W-1:0]           pick_task;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign full_slice = (slice_len_reg == '0) ? prrs_pkg::SLICE_W'(1) : slice_len_reg;

    assign rsp.valid      = out_valid_reg;
    assign rsp.run_task   = out_run_reg;
    assign rsp.switch_now = out_switch_reg;
    assign rsp.none_ready = out_none_reg;
    assign rsp.lock_depth = out_lock_reg;

    // Build the row of slot cells and the pick chain through them
    assign chain[0] = '0;
    for (genvar g = 0; g < prrs_pkg::MAX_TASKS; g++)
    begin : g_cell
        prrs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (prrs_pkg::ID_W'(g)),
            .bc       (bc),
            .pick_in  (chain[g]),
            .stat     (stat[g]),
            .pick_out (chain[g+1])
        );
        assign ready_vec[g] = stat[g].ready;
    end

    // Count ready peers of the current task for a tail insertion
    always_comb
    begin
        peer_cnt = '0;
        for (int i = 0; i < prrs_pkg::MAX_TASKS; i++)
        begin
            if (prrs_pkg::ID_W'(i) != cur_reg && stat[i].ready &&
                stat[i].prio == stat[cur_reg].prio)
                peer_cnt = peer_cnt + (prrs_pkg::RANK_W+1)'(1);
        end
    end

    // Drive the broadcast operation for the current step
    always_comb
    begin
        bc       = '0;
        bc.op    = prrs_pkg::OP_NOP;
        bc.full  = full_slice;
        case (state_reg)
            S_CREATE_RM:
            begin
                bc.tgt  = tid_reg;
                bc.prio = stat[tid_reg].prio;
                bc.rank = stat[tid_reg].rank;
                if (stat[tid_reg].ready)
                    bc.op = prrs_pkg::OP_REMOVE;
            end
            S_CREATE_ADD:
            begin
                bc.op   = prrs_pkg::OP_CREATE;
                bc.tgt  = tid_reg;
                bc.prio = prio_reg;
            end
            S_DELAY:
            begin
                bc.tgt   = cur_reg;
                bc.prio  = stat[cur_reg].prio;
                bc.rank  = stat[cur_reg].rank;
                bc.delay = (dly_reg == '0) ? prrs_pkg::DELAY_BITS'(1) : dly_reg;
                if (cur_valid_reg && stat[cur_reg].ready)
                    bc.op = prrs_pkg::OP_DELAY;
            end
            S_TICK_SCAN:
            begin
                bc.tgt  = scan_reg;
                bc.prio = stat[scan_reg].prio;
                if (stat[scan_reg].used && stat[scan_reg].delayed)
                begin
                    if (stat[scan_reg].dl <= prrs_pkg::DELAY_BITS'(1))
                        bc.op = prrs_pkg::OP_WAKE;
                    else
                        bc.op = prrs_pkg::OP_DEC;
                end
            end
            S_TICK_SLICE:
            begin
                bc.tgt  = cur_reg;
                bc.prio = stat[cur_reg].prio;
                bc.rank = stat[cur_reg].rank;
                bc.tail = peer_cnt[prrs_pkg::RANK_W-1:0];
                if (cur_valid_reg)
                begin
                    if (stat[cur_reg].slice > prrs_pkg::SLICE_W'(1))
                        bc.op = prrs_pkg::OP_SLICE_DEC;
                    else if (stat[cur_reg].ready)
                        bc.op = prrs_pkg::OP_SLICE_ROT;
                    else
                        bc.op = prrs_pkg::OP_SLICE_RELOAD;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Apply the lock rule to the winner of the pick chain
    assign pick_valid = (lock_reg == '0) ? chain[prrs_pkg::MAX_TASKS].found : cur_valid_reg;
    assign pick_task  = (lock_reg == '0 && chain[prrs_pkg::MAX_TASKS].found) ?
                        chain[prrs_pkg::MAX_TASKS].idx : cur_reg;

    // Sequence the request, hold the lock count, register the response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            cur_reg        <= '0;
            cur_valid_reg  <= 1'b0;
            lock_reg       <= '0;
            slice_len_reg  <= prrs_pkg::SLICE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                slice_len_reg <= cfg.data;
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        tid_reg  <= req.task_id;
                        prio_reg <= req.task_prio;
                        dly_reg  <= req.delay_ticks;
                        scan_reg <= '0;
                        case (req.cmd)
                            prrs_pkg::CMD_CREATE: state_reg <= S_CREATE_RM;
                            prrs_pkg::CMD_DELAY:  state_reg <= S_DELAY;
                            prrs_pkg::CMD_TICK:   state_reg <= S_TICK_SCAN;
                            prrs_pkg::CMD_LOCK:
                            begin
                                if (lock_reg != prrs_pkg::LOCK_MAX)
                                    lock_reg <= lock_reg + 1'b1;
                                state_reg <= S_PICK;
                            end
                            prrs_pkg::CMD_UNLOCK:
                            begin
                                if (lock_reg != '0)
                                    lock_reg <= lock_reg - 1'b1;
                                state_reg <= S_PICK;
                            end
                            default: state_reg <= S_PICK;
                        endcase
                    end
                end
                S_CREATE_RM:  state_reg <= S_CREATE_ADD;
                S_CREATE_ADD: state_reg <= S_PICK;
                S_DELAY:      state_reg <= S_PICK;
                S_TICK_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == prrs_pkg::ID_W'(prrs_pkg::MAX_TASKS - 1))
                        state_reg <= S_TICK_SLICE;
                end
                S_TICK_SLICE: state_reg <= S_PICK;
                S_PICK:
                begin
                    if (out_free)
                    begin
                        cur_valid_reg  <= pick_valid;
                        cur_reg        <= pick_task;
                        out_valid_reg  <= 1'b1;
                        out_run_reg    <= pick_valid ? pick_task : '0;
                        out_switch_reg <= pick_valid &&
                                          (!cur_valid_reg || cur_reg != pick_task);
                        out_none_reg   <= !chain[prrs_pkg::MAX_TASKS].found;
                        out_lock_reg   <= lock_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Unlocked and idle: a current task exists exactly when some slot is ready
    a_cur_matches_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && lock_reg == '0) |-> (cur_valid_reg == (|ready_vec)))
        else $error("current task presence disagrees with ready slots");

    // Unlocked and idle: the current task is itself ready
    a_cur_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && lock_reg == '0 && cur_valid_reg) |-> ready_vec[cur_reg])
        else $error("current task is not ready");

    // A response is only produced when leaving the pick step
    a_rsp_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PICK))
        else $error("response raised outside the pick step");

endmodule

@@ test/prrs_sched_checker.sv @@
// Watches the request, response and config channels of the task scheduler.
// Predicts each scheduling decision and compares it with the response.
// Depends on prrs_pkg and the prrs_req_if, prrs_rsp_if, prrs_cfg_if interfaces.
module prrs_sched_checker
    import prrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    prrs_req_if  req,
    prrs_rsp_if  rsp,
    prrs_cfg_if  cfg,
    output int   fail_count,
    output int   pending_decisions
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ID_W-1:0]   run_task;
        logic              switch_now;
        logic              none_ready;
        logic [LOCK_W-1:0] lock_depth;
    } sched_decision_t;

    // Shadow copy of the slot table and scheduler state
    bit                  slot_used    [MAX_TASKS];
    bit                  slot_ready   [MAX_TASKS];
    bit                  slot_sleep   [MAX_TASKS];
    logic [PRIO_W-1:0]   slot_prio    [MAX_TASKS];
    logic [DELAY_BITS-1:0] sleep_left [MAX_TASKS];
    logic [SLICE_W-1:0]  slice_left   [MAX_TASKS];
    int                  queue_pos    [MAX_TASKS];
    int                  running_slot;
    bit                  running_ok;
    logic [LOCK_W-1:0]   lock_level;
    logic [SLICE_W-1:0]  slice_len;

    sched_decision_t expected_decisions[$];

    function automatic logic [SLICE_W-1:0] reload_slice();
        return (slice_len == 0) ? 8'd1 : slice_len;
    endfunction

    // Unlink a slot from its priority queue
    function automatic void unlink_slot(int t);
        for (int i = 0; i < MAX_TASKS; i++)
            if (i != t && slot_ready[i] && slot_prio[i] == slot_prio[t]
                && queue_pos[i] > queue_pos[t])
                queue_pos[i]--;
        slot_ready[t] = 0;
        queue_pos[t] = 0;
    endfunction

    function automatic void push_head(int t);
        for (int i = 0; i < MAX_TASKS; i++)
            if (i != t && slot_ready[i] && slot_prio[i] == slot_prio[t])
                queue_pos[i]++;
        slot_ready[t] = 1;
        queue_pos[t] = 0;
    endfunction

    function automatic void push_tail(int t);
        int n;
        n = 0;
        for (int i = 0; i < MAX_TASKS; i++)
            if (i != t && slot_ready[i] && slot_prio[i] == slot_prio[t])
                n++;
        slot_ready[t] = 1;
        queue_pos[t] = n;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            slot_used[i] = 0;
            slot_ready[i] = 0;
            slot_sleep[i] = 0;
            slot_prio[i] = '0;
            sleep_left[i] = '0;
            slice_left[i] = '0;
            queue_pos[i] = 0;
        end
        running_slot = 0;
        running_ok = 0;
        lock_level = '0;
        slice_len = SLICE_RESET;
    endfunction

    // Apply one request to the shadow state and return the decision it yields
    function automatic sched_decision_t schedule_request(logic [CMD_W-1:0] cmd,
            logic [ID_W-1:0] tid, logic [PRIO_W-1:0] prio, logic [DELAY_BITS-1:0] ticks);
        sched_decision_t d;
        bit prev_ok;
        int prev_slot;
        int best;
        bit any;
        int t;
        prev_ok = running_ok;
        prev_slot = running_slot;
        case (cmd)
            CMD_CREATE:
            begin
                t = int'(tid);
                if (slot_ready[t])
                    unlink_slot(t);
                slot_sleep[t] = 0;
                sleep_left[t] = '0;
                slot_used[t] = 1;
                slot_prio[t] = prio;
                slice_left[t] = reload_slice();
                push_head(t);
            end
            CMD_DELAY:
            begin
                t = running_slot;
                if (running_ok && slot_ready[t])
                begin
                    unlink_slot(t);
                    slot_sleep[t] = 1;
                    sleep_left[t] = (ticks == 0) ? 16'd1 : ticks;
                end
            end
            CMD_TICK:
            begin
                // wake in ascending slot order, each to its queue head
                for (int i = 0; i < MAX_TASKS; i++)
                begin
                    if (slot_used[i] && slot_sleep[i])
                    begin
                        if (sleep_left[i] > 0)
                            sleep_left[i]--;
                        if (sleep_left[i] == 0)
                        begin
                            slot_sleep[i] = 0;
                            push_head(i);
                        end
                    end
                end
                if (running_ok)
                begin
                    t = running_slot;
                    if (slice_left[t] <= 1)
                    begin
                        if (slot_ready[t])
                        begin
                            unlink_slot(t);
                            push_tail(t);
                        end
                        slice_left[t] = reload_slice();
                    end
                    else
                        slice_left[t]--;
                end
            end
            CMD_LOCK:
                if (lock_level != LOCK_MAX)
                    lock_level++;
            CMD_UNLOCK:
                if (lock_level != 0)
                    lock_level--;
            default: ;
        endcase

        // pick the head of the highest non-empty priority
        any = 0;
        best = 0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (slot_ready[i] && (!any || slot_prio[i] < slot_prio[best]
                || (slot_prio[i] == slot_prio[best] && queue_pos[i] < queue_pos[best])))
            begin
                best = i;
                any = 1;
            end
        end
        if (lock_level == 0)
        begin
            running_ok = any;
            if (any)
                running_slot = best;
        end

        d.run_task = running_ok ? running_slot[ID_W-1:0] : '0;
        d.switch_now = running_ok && (!prev_ok || prev_slot != running_slot);
        d.none_ready = !any;
        d.lock_depth = lock_level;
        return d;
    endfunction

    // Track config writes, predict on accepted requests, compare on responses
    always @(posedge clk or negedge rst_n)
    begin
        sched_decision_t want;
        sched_decision_t got;
        int errs;
        if (!rst_n)
        begin
            clear_table();
            expected_decisions.delete();
            fail_count <= 0;
            pending_decisions <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg.valid && cfg.ready)
                slice_len = cfg.data;
            if (req.valid && req.ready)
                expected_decisions.push_back(schedule_request(req.cmd, req.task_id,
                    req.task_prio, req.delay_ticks));
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.run_task, rsp.switch_now, rsp.none_ready, rsp.lock_depth};
                if (expected_decisions.size() == 0)
                begin
                    $display("%0t: unexpected response %p", $time, got);
                    errs++;
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (want.run_task !== got.run_task)
                    begin
                        $display("%0t: run_task expected %0d actual %0d",
                            $time, want.run_task, got.run_task);
                        errs++;
                    end
                    if (want.switch_now !== got.switch_now)
                    begin
                        $display("%0t: switch_now expected %0b actual %0b",
                            $time, want.switch_now, got.switch_now);
                        errs++;
                    end
                    if (want.none_ready !== got.none_ready)
                    begin
                        $display("%0t: none_ready expected %0b actual %0b",
                            $time, want.none_ready, got.none_ready);
                        errs++;
                    end
                    if (want.lock_depth !== got.lock_depth)
                    begin
                        $display("%0t: lock_depth expected %0d actual %0d",
                            $time, want.lock_depth, got.lock_depth);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            pending_decisions <= expected_decisions.size();
        end
    end
endmodule

@@ test/priority_round_robin_task_scheduler_test.sv @@
// Top of the scheduler testbench: clock, reset, request stimulus and response stalls.
// Depends on prrs_pkg, the channel interfaces, the scheduler and prrs_sched_checker.
module priority_round_robin_task_scheduler_test;
    import prrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_decisions;
    int   burst_left;
    int   hold_cycles;
    bit   hold_request;

    prrs_req_if req ();
    prrs_rsp_if rsp ();
    prrs_cfg_if cfg ();

    priority_round_robin_task_scheduler uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    prrs_sched_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req),
        .rsp               (rsp),
        .cfg               (cfg),
        .fail_count        (fail_count),
        .pending_decisions (pending_decisions)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Stall the response side: changing patterns plus one long hold-off on request
    initial
    begin
        int stall_mode;
        int phase_left;
        rsp.ready = 1'b0;
        stall_mode = 0;
        phase_left = 0;
        hold_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_cycles == 0)
            begin
                hold_cycles = 300;
                hold_request = 0;
            end
            if (phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp.ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= 1'($urandom_range(0, 1));
                    2: rsp.ready <= ($urandom_range(0, 9) != 0);
                    default: rsp.ready <= ($urandom_range(0, 9) < 2);
                endcase
        end
    end

    // Offer one request and hold it until accepted; drop valid for a gap between bursts
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] tid,
            logic [PRIO_W-1:0] prio, logic [DELAY_BITS-1:0] ticks);
        int gap;
        req.valid <= 1'b1;
        req.cmd <= cmd;
        req.task_id <= tid;
        req.task_prio <= prio;
        req.delay_ticks <= ticks;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Wait until every decision has arrived and the block has settled
    task automatic drain();
        while (req.valid || pending_decisions != 0)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic write_slice(logic [SLICE_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [DELAY_BITS-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DELAY_BITS'($urandom_range(0, 65535));
            2: return 16'hFFFF;
            default: return DELAY_BITS'($urandom_range(1, 6));
        endcase
    endfunction

    // Mostly well-formed traffic: creates in a few shared priorities, naps, ticks, locks and unlocks
    task automatic random_requests(int count);
        int w;
        logic [CMD_W-1:0] cmd;
        logic [PRIO_W-1:0] prio;
        for (int n = 0; n < count; n++)
        begin
            w = $urandom_range(0, 99);
            if (w < 22)
                cmd = CMD_CREATE;
            else if (w < 42)
                cmd = CMD_DELAY;
            else if (w < 84)
                cmd = CMD_TICK;
            else if (w < 91)
                cmd = CMD_LOCK;
            else if (w < 98)
                cmd = CMD_UNLOCK;
            else
                cmd = CMD_W'($urandom_range(5, 7));
            prio = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(0, 31))
                                                : PRIO_W'($urandom_range(0, 3));
            send_request(cmd, ID_W'($urandom_range(0, 7)), prio, pick_delay());
            if (n == count / 2 && $urandom_range(0, 1) == 0)
                hold_request = 1;
        end
    endtask

    initial
    begin
        logic [SLICE_W-1:0] slice_plan[5];
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_TICK;
        req.task_id = '0;
        req.task_prio = '0;
        req.delay_ticks = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        hold_request = 0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, rewrites, locking and a double wake
        send_request(CMD_DELAY, 3'd0, 5'd0, 16'd5);
        send_request(CMD_UNLOCK, 3'd0, 5'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 5'd0, 16'd0);
        send_request(CMD_CREATE, 3'd7, 5'd31, 16'hFFFF);
        send_request(CMD_CREATE, 3'd0, 5'd0, 16'd0);
        send_request(CMD_CREATE, 3'd5, 5'd0, 16'd0);
        send_request(CMD_CREATE, 3'd2, 5'd3, 16'd0);
        send_request(CMD_CREATE, 3'd5, 5'd3, 16'd0);
        send_request(CMD_CREATE, 3'd0, 5'd0, 16'd0);
        send_request(CMD_DELAY, 3'd0, 5'd0, 16'd1);
        send_request(CMD_DELAY, 3'd0, 5'd0, 16'd1);
        send_request(CMD_TICK, 3'd0, 5'd0, 16'd0);
        send_request(CMD_DELAY, 3'd0, 5'd0, 16'd0);
        send_request(CMD_DELAY, 3'd0, 5'd0, 16'hFFFF);
        send_request(3'd5, 3'd7, 5'd31, 16'hFFFF);
        send_request(3'd6, 3'd0, 5'd0, 16'd0);
        send_request(3'd7, 3'd3, 5'd12, 16'h5A5A);
        send_request(CMD_LOCK, 3'd0, 5'd0, 16'd0);
        send_request(CMD_DELAY, 3'd0, 5'd0, 16'd2);
        send_request(CMD_TICK, 3'd0, 5'd0, 16'd0);
        send_request(CMD_CREATE, 3'd1, 5'd0, 16'd0);
        send_request(CMD_UNLOCK, 3'd0, 5'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 5'd0, 16'd0);

        // Random phases, each with its own slice length
        slice_plan = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd10};
        slice_plan[4] = SLICE_W'($urandom_range(1, 255));
        hold_request = 1;
        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_slice(slice_plan[p]);
            random_requests(40);
        end

        // Saturate the lock count at the top, then unwind past zero
        repeat (256) send_request(CMD_LOCK, ID_W'($urandom_range(0, 7)), 5'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 5'd0, 16'd0);
        repeat (256) send_request(CMD_UNLOCK, ID_W'($urandom_range(0, 7)), 5'd0, 16'd0);
        random_requests(20);

        drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
